>>> design/ssstat_pkg.sv
package ssstat_pkg;

   localparam int DEPTH    = 64;
   localparam int SAMPLE_W = 8;
   localparam int RANK_W   = 6;
   localparam int SUM_W    = 14;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int STEP_W   = $clog2(SUM_W + 1);

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                final_sample;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0]   rank;
      logic [SAMPLE_W-1:0] sorted_value;
      logic [SAMPLE_W-1:0] mean_value;
      logic [SAMPLE_W-1:0] median_value;
      logic [SAMPLE_W-1:0] largest;
      logic [SAMPLE_W-1:0] smallest;
      logic                overflowed;
      logic                end_of_run;
   } rsp_type;

   typedef struct packed {
      logic                insert;
      logic                rotate;
      logic [SAMPLE_W-1:0] sample;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

>>> design/ssstat_cell.sv
module ssstat_cell (
   input  logic                             clock,
   input  ssstat_pkg::cell_ctrl_type        ctrl,
   input  logic                             occupied,
   input  logic [ssstat_pkg::SAMPLE_W-1:0]  prev_val,
   input  logic                             prev_take,
   input  logic [ssstat_pkg::SAMPLE_W-1:0]  next_val,
   output logic [ssstat_pkg::SAMPLE_W-1:0]  val,
   output logic                             take
);

   logic [ssstat_pkg::SAMPLE_W-1:0] val_ff;
   logic [ssstat_pkg::SAMPLE_W-1:0] val_in;

   // A cell gives way when it is empty or holds a strictly smaller value.
   assign take = !occupied || (ctrl.sample > val_ff);
   assign val  = val_ff;

   always_comb begin
      val_in = val_ff;
      if (ctrl.insert && take) begin
         val_in = prev_take ? prev_val : ctrl.sample;
      end else if (ctrl.rotate) begin
         val_in = next_val;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

>>> design/ssstat_div.sv
module ssstat_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ssstat_pkg::SUM_W-1:0]   dividend,
   input  logic [ssstat_pkg::CNT_W-1:0]   divisor,
   output logic                           busy,
   output logic [ssstat_pkg::SUM_W-1:0]   quotient
);

   logic [ssstat_pkg::SUM_W-1:0]  quo_ff;
   logic [ssstat_pkg::SUM_W-1:0]  quo_in;
   logic [ssstat_pkg::CNT_W-1:0]  rem_ff;
   logic [ssstat_pkg::CNT_W-1:0]  rem_in;
   logic [ssstat_pkg::CNT_W-1:0]  dvs_ff;
   logic [ssstat_pkg::CNT_W-1:0]  dvs_in;
   logic [ssstat_pkg::STEP_W-1:0] step_ff;
   logic [ssstat_pkg::STEP_W-1:0] step_in;
   logic                          busy_ff;
   logic                          busy_in;
   logic [ssstat_pkg::CNT_W:0]    trial;
   logic                          fits;

   assign trial = {rem_ff, quo_ff[ssstat_pkg::SUM_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[ssstat_pkg::SUM_W-2:0], fits};
         rem_in  = fits ? ssstat_pkg::CNT_W'(trial - {1'b0, dvs_ff})
                        : ssstat_pkg::CNT_W'(trial);
         step_in = step_ff + ssstat_pkg::STEP_W'(1);
         if (step_ff == ssstat_pkg::STEP_W'(ssstat_pkg::SUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> design/sorted_set_statistics_top.sv
// Channel  | Direction | Handshake              | Payload
// req      | in        | req_valid / req_ready  | req_data (sample, final_sample)
// rsp      | out       | rsp_valid / rsp_ready  | rsp_data (rank, value, statistics)
//
// Loading takes one request per cycle; each sample is inserted by the cell chain in that cycle
// while the set has room, else dropped and flagged as overflow. The final request starts a scan
// that rotates the chain once, while the 14-step serial divider forms the mean; the scan ends
// once both are done. The burst then gives n responses, one per cycle while rsp_ready is high.
// Synchronous reset empties the set; no request is taken during the scan and the burst.
module sorted_set_statistics_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ssstat_pkg::req_type   req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ssstat_pkg::rsp_type   rsp_data
);

   localparam int CW = ssstat_pkg::CNT_W;
   localparam int SW = ssstat_pkg::SAMPLE_W;

   ssstat_pkg::state_type         state_ff;
   ssstat_pkg::state_type         state_in;
   logic [CW-1:0]                 count_ff;
   logic [CW-1:0]                 count_in;
   logic [ssstat_pkg::SUM_W-1:0]  sum_ff;
   logic [ssstat_pkg::SUM_W-1:0]  sum_in;
   logic                          ovf_ff;
   logic                          ovf_in;
   logic [CW-1:0]                 scan_ix_ff;
   logic [CW-1:0]                 scan_ix_in;
   logic [ssstat_pkg::IDX_W-1:0]  out_ix_ff;
   logic [ssstat_pkg::IDX_W-1:0]  out_ix_in;
   logic                          div_start_ff;
   logic                          div_start_in;
   logic [SW-1:0]                 largest_ff;
   logic [SW-1:0]                 largest_in;
   logic [SW-1:0]                 smallest_ff;
   logic [SW-1:0]                 smallest_in;
   logic [SW-1:0]                 med_a_ff;
   logic [SW-1:0]                 med_a_in;
   logic [SW-1:0]                 med_b_ff;
   logic [SW-1:0]                 med_b_in;

   logic                          req_acc;
   logic                          rsp_acc;
   logic                          has_room;
   logic                          scanning;
   logic                          last_out;
   logic [CW-1:0]                 half;
   logic [SW:0]                   med_sum;
   logic                          div_busy;
   logic [ssstat_pkg::SUM_W-1:0]  div_quo;
   ssstat_pkg::cell_ctrl_type     ctrl;
   logic [SW-1:0]                 cell_val  [ssstat_pkg::DEPTH];
   logic                          cell_take [ssstat_pkg::DEPTH];

   assign req_acc  = req_valid && req_ready;
   assign rsp_acc  = rsp_valid && rsp_ready;
   assign has_room = count_ff < CW'(ssstat_pkg::DEPTH);
   assign scanning = (state_ff == ssstat_pkg::ST_SCAN) && (scan_ix_ff != count_ff);
   assign last_out = (CW'(out_ix_ff) + CW'(1)) == count_ff;
   assign half     = count_ff >> 1;
   assign med_sum  = {1'b0, med_a_ff} + {1'b0, med_b_ff};

   assign ctrl.insert = req_acc && has_room;
   assign ctrl.rotate = scanning || rsp_acc;
   assign ctrl.sample = req_data.sample;

   for (genvar i = 0; i < ssstat_pkg::DEPTH; i++) begin : g_cell
      logic [SW-1:0] prev_val;
      logic          prev_take;
      logic [SW-1:0] next_val;

      if (i == 0) begin : g_head
         assign prev_val  = '0;
         assign prev_take = 1'b0;
      end else begin : g_body
         assign prev_val  = cell_val[i-1];
         assign prev_take = cell_take[i-1];
      end

      if (i == ssstat_pkg::DEPTH - 1) begin : g_tail
         assign next_val = cell_val[0];
      end else begin : g_mid
         assign next_val = (CW'(i + 1) == count_ff) ? cell_val[0] : cell_val[i+1];
      end

      ssstat_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (CW'(i) < count_ff),
         .prev_val  (prev_val),
         .prev_take (prev_take),
         .next_val  (next_val),
         .val       (cell_val[i]),
         .take      (cell_take[i])
      );
   end

   ssstat_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssstat_pkg::ST_LOAD: begin
            if (req_acc && req_data.final_sample) begin
               state_in = ssstat_pkg::ST_SCAN;
            end
         end
         ssstat_pkg::ST_SCAN: begin
            if (!scanning && !div_busy && !div_start_ff) begin
               state_in = ssstat_pkg::ST_DRAIN;
            end
         end
         ssstat_pkg::ST_DRAIN: begin
            if (rsp_acc && last_out) begin
               state_in = ssstat_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = ssstat_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ssstat_pkg::ST_LOAD:  req_ready = 1'b1;
         ssstat_pkg::ST_SCAN:  req_ready = 1'b0;
         ssstat_pkg::ST_DRAIN: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      scan_ix_in   = scan_ix_ff;
      out_ix_in    = out_ix_ff;
      div_start_in = 1'b0;
      largest_in   = largest_ff;
      smallest_in  = smallest_ff;
      med_a_in     = med_a_ff;
      med_b_in     = med_b_ff;
      if (req_acc) begin
         if (has_room) begin
            count_in = count_ff + CW'(1);
            sum_in   = sum_ff + ssstat_pkg::SUM_W'(req_data.sample);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_data.final_sample) begin
            scan_ix_in   = '0;
            out_ix_in    = '0;
            div_start_in = 1'b1;
         end
      end
      if (scanning) begin
         scan_ix_in = scan_ix_ff + CW'(1);
         if (scan_ix_ff == '0) begin
            largest_in = cell_val[0];
         end
         if ((scan_ix_ff + CW'(1)) == half) begin
            med_a_in = cell_val[0];
         end
         if (scan_ix_ff == half) begin
            med_b_in = cell_val[0];
         end
         if ((scan_ix_ff + CW'(1)) == count_ff) begin
            smallest_in = cell_val[0];
         end
      end
      if (rsp_acc) begin
         out_ix_in = out_ix_ff + ssstat_pkg::IDX_W'(1);
         if (last_out) begin
            count_in = '0;
            sum_in   = '0;
            ovf_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      largest_ff  <= largest_in;
      smallest_ff <= smallest_in;
      med_a_ff    <= med_a_in;
      med_b_ff    <= med_b_in;
      out_ix_ff   <= out_ix_in;
      if (reset) begin
         state_ff     <= ssstat_pkg::ST_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         scan_ix_ff   <= '0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         scan_ix_ff   <= scan_ix_in;
         div_start_ff <= div_start_in;
      end
   end

   always_comb begin
      rsp_data.rank         = ssstat_pkg::RANK_W'(out_ix_ff);
      rsp_data.sorted_value = cell_val[0];
      rsp_data.mean_value   = SW'(div_quo);
      rsp_data.median_value = count_ff[0] ? med_b_ff : med_sum[SW:1];
      rsp_data.largest      = largest_ff;
      rsp_data.smallest     = smallest_ff;
      rsp_data.overflowed   = ovf_ff;
      rsp_data.end_of_run   = last_out;
   end

endmodule

>>> bench/tb_sorted_set_statistics_top.sv
`timescale 1ns / 1ps

module tb_sorted_set_statistics_top;

   localparam int LONG_HOLD    = 400;
   localparam int RANDOM_ITEMS = 150;
   localparam int SETTLE       = 40;

   typedef enum int {
      VALUES_FULL,
      VALUES_NARROW,
      VALUES_EXTREME
   } value_mix_type;

   logic                logic_unused_guard;
   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   ssstat_pkg::req_type req_data;
   logic                rsp_valid;
   logic                rsp_ready;
   ssstat_pkg::rsp_type rsp_data;

   logic [ssstat_pkg::SAMPLE_W-1:0] held_values[$];
   logic [ssstat_pkg::SUM_W-1:0]    sum_acc = '0;
   bit                              dropped_flag = 1'b0;
   ssstat_pkg::rsp_type             expected_burst[$];
   ssstat_pkg::rsp_type             burst_head;

   bit send_gaps     = 1'b0;
   bit recv_stalls   = 1'b0;
   bit hold_request  = 1'b0;

   int error_count     = 0;
   int requests_sent   = 0;
   int sets_closed     = 0;
   int overflow_sets   = 0;
   int results_checked = 0;

   assign logic_unused_guard = 1'b0;

   sorted_set_statistics_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ssstat_pkg::SAMPLE_W-1:0] pick_sample(
         value_mix_type mix, logic [ssstat_pkg::SAMPLE_W-1:0] base);
      case (mix)
         VALUES_FULL: begin
            return ssstat_pkg::SAMPLE_W'($urandom_range(0, 255));
         end
         VALUES_NARROW: begin
            return ssstat_pkg::SAMPLE_W'(base + $urandom_range(0, 3));
         end
         default: begin
            return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         end
      endcase
   endfunction

   // Mirrors the sorted store; a closing request turns it into one expected burst.
   function automatic void absorb_request(ssstat_pkg::req_type r);
      int                              pos;
      int                              n;
      int                              mean_int;
      logic [ssstat_pkg::SAMPLE_W:0]   mid_sum;
      logic [ssstat_pkg::SAMPLE_W-1:0] med;
      ssstat_pkg::rsp_type             e;
      if (held_values.size() == ssstat_pkg::DEPTH) begin
         dropped_flag = 1'b1;
      end else begin
         pos = held_values.size();
         for (int i = 0; i < held_values.size(); i++) begin
            if (held_values[i] < r.sample) begin
               pos = i;
               break;
            end
         end
         held_values.insert(pos, r.sample);
         sum_acc = sum_acc + ssstat_pkg::SUM_W'(r.sample);
      end
      if (r.final_sample) begin
         n = held_values.size();
         mean_int = int'(sum_acc) / n;
         if (n % 2 == 1) begin
            med = held_values[n / 2];
         end else begin
            mid_sum = {1'b0, held_values[n / 2 - 1]} + {1'b0, held_values[n / 2]};
            med = mid_sum[ssstat_pkg::SAMPLE_W:1];
         end
         for (int i = 0; i < n; i++) begin
            e.rank         = ssstat_pkg::RANK_W'(i);
            e.sorted_value = held_values[i];
            e.mean_value   = ssstat_pkg::SAMPLE_W'(mean_int);
            e.median_value = med;
            e.largest      = held_values[0];
            e.smallest     = held_values[n - 1];
            e.overflowed   = dropped_flag;
            e.end_of_run   = (i == n - 1);
            expected_burst.push_back(e);
         end
         sets_closed++;
         if (dropped_flag) overflow_sets++;
         held_values.delete();
         sum_acc = '0;
         dropped_flag = 1'b0;
      end
   endfunction

   task automatic send_sample(input logic [ssstat_pkg::SAMPLE_W-1:0] value,
                              input logic is_last);
      int gap;
      ssstat_pkg::req_type r;
      gap = send_gaps ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.sample = value;
      r.final_sample = is_last;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      absorb_request(r);
      requests_sent++;
   endtask

   task automatic send_random_set(input int size, input value_mix_type mix);
      logic [ssstat_pkg::SAMPLE_W-1:0] base;
      base = ssstat_pkg::SAMPLE_W'($urandom_range(0, 252));
      for (int k = 0; k < size; k++) begin
         send_sample(pick_sample(mix, base), k == size - 1);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_burst.size() != 0);
   endtask

   task automatic test_directed();
      logic [ssstat_pkg::SAMPLE_W-1:0] vals [0:23];
      int sizes [0:7];
      int idx;
      vals = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd254, 8'd255, 8'd1, 8'd2, 8'd3,
               8'd7, 8'd7, 8'd7, 8'd7, 8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd127,
               8'd10, 8'd200, 8'd10, 8'd200, 8'd10};
      sizes = '{1, 1, 2, 2, 3, 4, 6, 5};
      send_gaps = 1'b0;
      recv_stalls = 1'b0;
      idx = 0;
      foreach (sizes[s]) begin
         for (int k = 0; k < sizes[s]; k++) begin
            send_sample(vals[idx], k == sizes[s] - 1);
            idx++;
         end
      end
   endtask

   task automatic test_store_overflow();
      send_gaps = 1'b1;
      recv_stalls = 1'b1;
      for (int k = 0; k < ssstat_pkg::DEPTH; k++) begin
         send_sample(8'hFF, k == ssstat_pkg::DEPTH - 1);
      end
      send_random_set(ssstat_pkg::DEPTH, VALUES_NARROW);
      send_random_set(ssstat_pkg::DEPTH + 1, VALUES_FULL);
      send_random_set(ssstat_pkg::DEPTH + 3, VALUES_EXTREME);
   endtask

   task automatic test_response_hold();
      send_gaps = 1'b0;
      recv_stalls = 1'b1;
      hold_request = 1'b1;
      repeat (4) send_random_set(12, VALUES_FULL);
   endtask

   task automatic test_drain_pause();
      send_gaps = 1'b1;
      recv_stalls = 1'b1;
      send_random_set(9, VALUES_FULL);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      send_random_set(5, VALUES_NARROW);
   endtask

   task automatic test_random_sets();
      int first_item;
      int r;
      int size;
      value_mix_type mix;
      first_item = requests_sent;
      while (requests_sent - first_item < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70) size = $urandom_range(1, 8);
         else if (r < 90) size = $urandom_range(9, 32);
         else if (r < 97) size = $urandom_range(33, ssstat_pkg::DEPTH);
         else size = $urandom_range(ssstat_pkg::DEPTH + 1, ssstat_pkg::DEPTH + 4);
         mix = value_mix_type'($urandom_range(0, 2));
         send_gaps = ($urandom_range(0, 4) != 0);
         recv_stalls = ($urandom_range(0, 4) != 0);
         send_random_set(size, mix);
      end
   endtask

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            hold_request = 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            stall = idle_len();
            repeat (stall) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic compare_field(input string name, input logic [7:0] rank_exp,
                                input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch at rank %0d, expected %0d, actual %0d",
                  $time, name, rank_exp, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_burst.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual rank %0d value %0d",
                     $time, rsp_data.rank, rsp_data.sorted_value);
            error_count++;
         end else begin
            burst_head = expected_burst.pop_front();
            compare_field("rank", burst_head.rank, burst_head.rank, rsp_data.rank);
            compare_field("sorted_value", burst_head.rank, burst_head.sorted_value,
                          rsp_data.sorted_value);
            compare_field("mean_value", burst_head.rank, burst_head.mean_value,
                          rsp_data.mean_value);
            compare_field("median_value", burst_head.rank, burst_head.median_value,
                          rsp_data.median_value);
            compare_field("largest", burst_head.rank, burst_head.largest, rsp_data.largest);
            compare_field("smallest", burst_head.rank, burst_head.smallest,
                          rsp_data.smallest);
            compare_field("overflowed", burst_head.rank, burst_head.overflowed,
                          rsp_data.overflowed);
            compare_field("end_of_run", burst_head.rank, burst_head.end_of_run,
                          rsp_data.end_of_run);
            results_checked++;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_store_overflow();
      test_response_hold();
      test_drain_pause();
      test_random_sets();

      wait_drained();
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d requests closing %0d data sets, %0d of them past the store depth.",
               requests_sent, sets_closed, overflow_sets);
      $display("Checked %0d sorted results with their statistics.", results_checked);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
design/ssstat_pkg.sv
design/ssstat_cell.sv
design/ssstat_div.sv
design/sorted_set_statistics_top.sv
bench/tb_sorted_set_statistics_top.sv
